// ===== rtl/gauge_needle_position_and_state_unit_assert.svh =====
// ----------------------------------------------------------------------------
// gauge needle assertion macros
// shared property forms for the gauge needle checkers
// ----------------------------------------------------------------------------
`ifndef GAUGE_NEEDLE_POSITION_AND_STATE_UNIT_ASSERT_SVH
`define GAUGE_NEEDLE_POSITION_AND_STATE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define GNP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define GNP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gnp_pkg.sv =====
// ----------------------------------------------------------------------------
// gnp_pkg
// types and codes shared by the gauge needle position and state unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gnp_pkg;

	localparam int POS_W  = 10;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	// signal kinds
	localparam logic [2:0] KIND_COOLANT  = 3'd0;
	localparam logic [2:0] KIND_BATTERY  = 3'd1;
	localparam logic [2:0] KIND_INJECTOR = 3'd2;
	localparam logic [2:0] KIND_KNOCK    = 3'd3;
	localparam logic [2:0] KIND_FLAGS    = 3'd4;
	localparam logic [2:0] KIND_NO_WARN  = 3'd5;

	// gauge states
	localparam logic [1:0] ST_NORMAL  = 2'd0;
	localparam logic [1:0] ST_WARNING = 2'd1;
	localparam logic [1:0] ST_STALE   = 2'd2;
	localparam logic [1:0] ST_NODATA  = 2'd3;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_COOLANT  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BATTERY  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_INJECTOR = 3'd2;
	localparam logic [CFG_IW-1:0] REG_KNOCK    = 3'd3;

	// position source
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_FULL = 2'd1;
	localparam logic [1:0] SEL_DIV  = 2'd2;

	typedef struct packed {
		logic [2:0]         signal_kind;
		logic signed [31:0] value;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
		logic               valid_req;
		logic               fresh;
		logic [31:0]        now_ms;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             off_scale;
		logic [1:0]       gauge_state;
	} out_t;

	typedef struct packed {
		logic signed [15:0] coolant_warn_level;
		logic [11:0]        battery_low_level;
		logic [13:0]        injector_duty_warn_level;
		logic [13:0]        knock_warn_level;
	} cfg_t;

	// what travels beside the divide
	typedef struct packed {
		logic [1:0] sel;
		logic       off_scale;
		logic [1:0] gauge_state;
	} side_t;

endpackage

// ===== rtl/gnp_front.sv =====
// ----------------------------------------------------------------------------
// gnp_front
// five stage front end: range checks, warning state, sweep phase by
// reciprocal multiply, and the dividend and divisor for the divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnp_front #(
	parameter int POSITION_FULL_SCALE = 1000,
	parameter int SWEEP_PERIOD_MS     = 2400
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  gnp_pkg::cfg_t                             cfg,
	input  logic                                      up_valid,
	output logic                                      up_ready,
	input  gnp_pkg::in_t                              up_data,
	output logic                                      dn_valid,
	input  logic                                      dn_ready,
	output logic [32+$clog2(POSITION_FULL_SCALE+1)-1:0] dn_num,
	output logic [31:0]                               dn_den,
	output gnp_pkg::side_t                            dn_side
);

	localparam int QW  = $clog2(POSITION_FULL_SCALE + 1);
	localparam int NW  = 32 + QW;
	localparam int PHW = $clog2(SWEEP_PERIOD_MS);
	localparam logic [63:0] RECIP_W = (64'd1 << 32) / SWEEP_PERIOD_MS;
	localparam logic [31:0] RECIP   = RECIP_W[31:0];
	localparam logic [15:0] PER16   = 16'(SWEEP_PERIOD_MS);
	localparam logic [31:0] PER32   = 32'(SWEEP_PERIOD_MS);
	localparam logic [PHW:0] PER_P  = (PHW+1)'(SWEEP_PERIOD_MS);
	localparam logic [PHW:0] HALF_P = (PHW+1)'(SWEEP_PERIOD_MS / 2);
	localparam logic [31:0] HALF32  = 32'(SWEEP_PERIOD_MS / 2);
	localparam logic [QW-1:0] FS    = QW'(POSITION_FULL_SCALE);

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !vld_s5 || dn_ready;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign up_ready = rdy1;
	assign dn_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= up_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: compares, state, reciprocal product
	logic signed [31:0] v, lo, hi;
	logic               warn;
	gnp_pkg::side_t     side_c;
	logic               sweep_c;
	logic [63:0]        rprod;

	always_comb begin
		v     = $signed(up_data.value);
		lo    = $signed(up_data.range_min);
		hi    = $signed(up_data.range_max);
		rprod = up_data.now_ms * RECIP;

		unique case (up_data.signal_kind)
			gnp_pkg::KIND_COOLANT:  warn = v >= $signed({{16{cfg.coolant_warn_level[15]}},
			                                            cfg.coolant_warn_level});
			gnp_pkg::KIND_BATTERY:  warn = v <= $signed({20'd0, cfg.battery_low_level});
			gnp_pkg::KIND_INJECTOR: warn = v >= $signed({18'd0, cfg.injector_duty_warn_level});
			gnp_pkg::KIND_KNOCK:    warn = v >= $signed({18'd0, cfg.knock_warn_level});
			gnp_pkg::KIND_FLAGS:    warn = v != 32'sd0;
			default:                warn = 1'b0;
		endcase

		sweep_c          = 1'b0;
		side_c.off_scale = 1'b0;
		side_c.sel       = gnp_pkg::SEL_ZERO;
		if (up_data.signal_kind > gnp_pkg::KIND_NO_WARN) begin
			side_c.gauge_state = gnp_pkg::ST_NODATA;
		end else if (!up_data.valid_req) begin
			side_c.gauge_state = gnp_pkg::ST_NODATA;
			side_c.sel         = gnp_pkg::SEL_DIV;
			sweep_c            = 1'b1;
		end else begin
			priority if (!up_data.fresh) side_c.gauge_state = gnp_pkg::ST_STALE;
			else if (warn)               side_c.gauge_state = gnp_pkg::ST_WARNING;
			else                         side_c.gauge_state = gnp_pkg::ST_NORMAL;

			priority if (hi <= lo) begin
				side_c.sel = gnp_pkg::SEL_ZERO;
			end else if (v <= lo) begin
				side_c.sel       = gnp_pkg::SEL_ZERO;
				side_c.off_scale = v < lo;
			end else if (v >= hi) begin
				side_c.sel       = gnp_pkg::SEL_FULL;
				side_c.off_scale = v > hi;
			end else begin
				side_c.sel = gnp_pkg::SEL_DIV;
			end
		end
	end

	gnp_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	logic           sweep_s1, sweep_s2, sweep_s3;
	logic [31:0]    span_s1, span_s2, span_s3;
	logic [31:0]    offset_s1, offset_s2, offset_s3;
	logic [31:0]    qest_s1;
	logic [31:0]    now_s1, now_s2;
	logic [31:0]    qp_s2;
	logic [PHW-1:0] phase_s3;
	logic [31:0]    numb_s4, den_s4;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1   <= side_c;
			sweep_s1  <= sweep_c;
			span_s1   <= up_data.range_max - up_data.range_min;
			offset_s1 <= up_data.value - up_data.range_min;
			qest_s1   <= rprod[63:32];
			now_s1    <= up_data.now_ms;
		end
	end

	// stage 2: quotient estimate times period
	logic [47:0] qp_full;
	assign qp_full = qest_s1 * PER16;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			side_s2   <= side_s1;
			sweep_s2  <= sweep_s1;
			span_s2   <= span_s1;
			offset_s2 <= offset_s1;
			now_s2    <= now_s1;
			qp_s2     <= qp_full[31:0];
		end
	end

	// stage 3: remainder is below twice the period, one correction
	logic [31:0] rem_c, phase_c;
	always_comb begin
		rem_c   = now_s2 - qp_s2;
		phase_c = (rem_c >= PER32) ? rem_c - PER32 : rem_c;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			side_s3   <= side_s2;
			sweep_s3  <= sweep_s2;
			span_s3   <= span_s2;
			offset_s3 <= offset_s2;
			phase_s3  <= phase_c[PHW-1:0];
		end
	end

	// stage 4: triangle distance, capped at half so the quotient stays in range
	logic [PHW:0] dist_c;
	always_comb begin
		if ({1'b0, phase_s3} < HALF_P) dist_c = {1'b0, phase_s3};
		else                           dist_c = PER_P - {1'b0, phase_s3};
		if (dist_c > HALF_P) dist_c = HALF_P;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			side_s4  <= side_s3;
			numb_s4  <= sweep_s3 ? 32'(dist_c) : offset_s3;
			den_s4   <= sweep_s3 ? HALF32 : span_s3;
		end
	end

	// stage 5: dividend = base times full scale
	logic [31+QW:0] num_full;
	assign num_full = numb_s4 * FS;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			dn_side <= side_s4;
			dn_den  <= den_s4;
			dn_num  <= num_full[NW-1:0];
		end
	end

endmodule

// ===== rtl/gnp_div.sv =====
// ----------------------------------------------------------------------------
// gnp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnp_div #(
	parameter int QW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  logic [32+QW-1:0] up_num,
	input  logic [31:0]      up_den,
	input  gnp_pkg::side_t   up_side,
	output logic             dn_valid,
	input  logic             dn_ready,
	output logic [QW-1:0]    dn_quot,
	output gnp_pkg::side_t   dn_side
);

	localparam int NW = 32 + QW;

	logic           vld_s  [QW];
	logic [QW:0]    rdy;
	logic [31:0]    rem_s  [QW];
	logic [QW-1:0]  word_s [QW];
	logic [31:0]    den_s  [QW];
	gnp_pkg::side_t side_s [QW];

	assign rdy[QW]   = dn_ready;
	assign up_ready  = rdy[0];
	assign dn_valid  = vld_s[QW-1];
	assign dn_quot   = word_s[QW-1];
	assign dn_side   = side_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic [31:0]    rem_i;
		logic [QW-1:0]  word_i;
		logic [31:0]    den_i;
		gnp_pkg::side_t side_i;
		logic           vld_i;
		logic [32:0]    trial;
		logic           take;

		if (k == 0) begin : g_first
			// high part is below the divisor since the quotient fits QW bits
			assign rem_i  = up_num[NW-1:QW];
			assign word_i = up_num[QW-1:0];
			assign den_i  = up_den;
			assign side_i = up_side;
			assign vld_i  = up_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign word_i = word_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign trial  = {rem_i, word_i[QW-1]};
		assign take   = trial >= {1'b0, den_i};
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= take ? 32'(trial - {1'b0, den_i}) : trial[31:0];
				word_s[k] <= {word_i[QW-2:0], take};
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

endmodule

// ===== rtl/gauge_needle_position_and_state_unit.sv =====
// ----------------------------------------------------------------------------
// gauge needle position and state unit
// path: the front end stages, one divider stage per quotient bit, then the output register
// throughput: one reading per cycle while the output is not stalled, set by the one-bit-per-stage divider
// every stage has its own valid, so bubbles close up under a stalled output
// reset clears all valids and loads the warning thresholds with their defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gauge_needle_position_and_state_unit #(
	parameter int POSITION_FULL_SCALE = 1000,
	parameter int SWEEP_PERIOD_MS     = 2400
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gnp_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [gnp_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                        reading_valid,
	output logic                        reading_ready,
	input  gnp_pkg::in_t                reading,
	output logic                        needle_valid,
	input  logic                        needle_ready,
	output gnp_pkg::out_t               needle
);

	localparam int QW = $clog2(POSITION_FULL_SCALE + 1);
	localparam logic [QW-1:0] FS = QW'(POSITION_FULL_SCALE);

	// threshold registers
	gnp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coolant_warn_level       <= 16'sd10500;
			cfg_q.battery_low_level        <= 12'd1150;
			cfg_q.injector_duty_warn_level <= 14'd8500;
			cfg_q.knock_warn_level         <= 14'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gnp_pkg::REG_COOLANT:  cfg_q.coolant_warn_level       <= $signed(cfg_data);
				gnp_pkg::REG_BATTERY:  cfg_q.battery_low_level        <= cfg_data[11:0];
				gnp_pkg::REG_INJECTOR: cfg_q.injector_duty_warn_level <= cfg_data[13:0];
				gnp_pkg::REG_KNOCK:    cfg_q.knock_warn_level         <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	logic               fr_valid, fr_ready;
	logic [32+QW-1:0]   fr_num;
	logic [31:0]        fr_den;
	gnp_pkg::side_t     fr_side;

	gnp_front #(
		.POSITION_FULL_SCALE (POSITION_FULL_SCALE),
		.SWEEP_PERIOD_MS     (SWEEP_PERIOD_MS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (reading_valid),
		.up_ready (reading_ready),
		.up_data  (reading),
		.dn_valid (fr_valid),
		.dn_ready (fr_ready),
		.dn_num   (fr_num),
		.dn_den   (fr_den),
		.dn_side  (fr_side)
	);

	logic           dv_valid, dv_ready;
	logic [QW-1:0]  dv_quot;
	gnp_pkg::side_t dv_side;

	gnp_div #(
		.QW (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fr_valid),
		.up_ready (fr_ready),
		.up_num   (fr_num),
		.up_den   (fr_den),
		.up_side  (fr_side),
		.dn_valid (dv_valid),
		.dn_ready (dv_ready),
		.dn_quot  (dv_quot),
		.dn_side  (dv_side)
	);

	// output register with final position select
	logic          out_vld_q;
	gnp_pkg::out_t out_q;
	gnp_pkg::out_t out_d;
	logic [QW-1:0] pos_c;

	always_comb begin
		unique case (dv_side.sel)
			gnp_pkg::SEL_FULL: pos_c = FS;
			gnp_pkg::SEL_DIV:  pos_c = dv_quot;
			default:           pos_c = '0;
		endcase
		out_d.position    = gnp_pkg::POS_W'(pos_c);
		out_d.off_scale   = dv_side.off_scale;
		out_d.gauge_state = dv_side.gauge_state;
	end

	assign dv_ready = !out_vld_q || needle_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dv_ready) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready) begin
			out_q <= out_d;
		end
	end

	assign needle_valid = out_vld_q;
	assign needle       = out_q;

endmodule

// ===== rtl/gnp_checker.sv =====
// ----------------------------------------------------------------------------
// gnp_checker
// port level checks on the needle word of the gauge needle unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gauge_needle_position_and_state_unit_assert.svh"

module gnp_checker #(
	parameter int POSITION_FULL_SCALE = 1000
) (
	input logic          clk,
	input logic          arst_n,
	input logic          needle_valid,
	input logic          needle_ready,
	input gnp_pkg::out_t needle
);

	localparam logic [gnp_pkg::POS_W-1:0] FS_POS = gnp_pkg::POS_W'(POSITION_FULL_SCALE);
	localparam bit FS_WIDE = POSITION_FULL_SCALE > ((1 << gnp_pkg::POS_W) - 1);

	// a stalled word holds
	`GNP_ASSERT_NEXT(a_needle_hold, needle_valid && !needle_ready, needle_valid && $stable(needle), "needle word changed while stalled")

	// needle never past full scale
	`GNP_ASSERT_NOW(a_pos_range, needle_valid, FS_WIDE || needle.position <= FS_POS, "needle position beyond full scale")

	// off scale pins the needle at an end and needs a reading
	`GNP_ASSERT_NOW(a_off_scale, needle_valid && needle.off_scale, (needle.position == '0 || needle.position == FS_POS) && needle.gauge_state != gnp_pkg::ST_NODATA, "off scale word not pinned or without data")

endmodule

bind gauge_needle_position_and_state_unit gnp_checker #(
	.POSITION_FULL_SCALE (POSITION_FULL_SCALE)
) u_gnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.needle_valid (needle_valid),
	.needle_ready (needle_ready),
	.needle       (needle)
);

// ===== tb/sv/tb_gauge_needle_position_and_state_unit.sv =====
// ----------------------------------------------------------------------------
// tb_gauge_needle_position_and_state_unit
// drives gauge readings through the needle unit and checks every needle word
// against an in-bench prediction of position, off-scale flag and gauge state,
// across several warning threshold settings, idle and stall mixes and a long
// output hold-off that backs the pipeline up into its input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gauge_needle_position_and_state_unit;

	localparam int FULL_SCALE  = 1000;
	localparam int SWEEP_MS    = 2400;
	localparam int LATENCY     = $clog2(FULL_SCALE + 1) + 6;
	localparam int STUCK_LIMIT = 2000;

	localparam logic [2:0] KIND_NO_ELEMENT = 3'd6;
	localparam logic [2:0] KIND_UNUSED     = 3'd7;

	localparam logic [gnp_pkg::CFG_IW-1:0] REG_SPARE_FIRST = gnp_pkg::REG_KNOCK + 1'b1;
	localparam logic [gnp_pkg::CFG_IW-1:0] REG_SPARE_LAST  = {gnp_pkg::CFG_IW{1'b1}};

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [gnp_pkg::CFG_IW-1:0]   cfg_index;
	logic [gnp_pkg::CFG_DW-1:0]   cfg_data;
	logic                         reading_valid;
	logic                         reading_ready;
	gnp_pkg::in_t                 reading;
	logic                         needle_valid;
	logic                         needle_ready = 1'b0;
	gnp_pkg::out_t                needle;

	// bench copy of the warning thresholds
	gnp_pkg::cfg_t thr;

	gnp_pkg::out_t needle_q[$];
	int   idle_pct;
	int   stall_pct;
	int   hold_left;
	int   sent_count;
	int   checked_count;
	int   setting_count;
	int   mismatches;
	int   stuck_cycles;

	gauge_needle_position_and_state_unit #(
		.POSITION_FULL_SCALE(FULL_SCALE),
		.SWEEP_PERIOD_MS(SWEEP_MS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.reading_valid(reading_valid),
		.reading_ready(reading_ready),
		.reading(reading),
		.needle_valid(needle_valid),
		.needle_ready(needle_ready),
		.needle(needle)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint warn_level(input logic [2:0] kind);
		longint t;
		case (kind)
			gnp_pkg::KIND_COOLANT:  t = longint'(thr.coolant_warn_level);
			gnp_pkg::KIND_BATTERY:  t = longint'(thr.battery_low_level);
			gnp_pkg::KIND_INJECTOR: t = longint'(thr.injector_duty_warn_level);
			gnp_pkg::KIND_KNOCK:    t = longint'(thr.knock_warn_level);
			default:                t = 0;
		endcase
		return t;
	endfunction

	function automatic gnp_pkg::out_t predict_needle(input gnp_pkg::in_t r);
		gnp_pkg::out_t o;
		longint unsigned phase, half, p;
		logic [31:0] span32, off32;
		longint v, t;
		logic warn;
		o = '0;
		p = 0;
		if (r.signal_kind > gnp_pkg::KIND_NO_WARN) begin
			o.gauge_state = gnp_pkg::ST_NODATA;
		end else if (!r.valid_req) begin
			// triangle sweep while nothing has arrived
			half = longint'(SWEEP_MS / 2);
			phase = {32'd0, r.now_ms} % SWEEP_MS;
			if (phase < half) begin
				p = phase * FULL_SCALE / half;
			end else begin
				p = (SWEEP_MS - phase) * FULL_SCALE / half;
			end
			if (p > FULL_SCALE) begin
				p = longint'(FULL_SCALE);
			end
			o.gauge_state = gnp_pkg::ST_NODATA;
		end else begin
			if ($signed(r.range_max) <= $signed(r.range_min)) begin
				p = 0;
			end else if ($signed(r.value) <= $signed(r.range_min)) begin
				o.off_scale = $signed(r.value) < $signed(r.range_min);
			end else if ($signed(r.value) >= $signed(r.range_max)) begin
				p = longint'(FULL_SCALE);
				o.off_scale = $signed(r.value) > $signed(r.range_max);
			end else begin
				span32 = r.range_max - r.range_min;
				off32 = r.value - r.range_min;
				p = {32'd0, off32} * FULL_SCALE / {32'd0, span32};
			end
			v = longint'($signed(r.value));
			t = warn_level(r.signal_kind);
			case (r.signal_kind)
				gnp_pkg::KIND_COOLANT, gnp_pkg::KIND_INJECTOR, gnp_pkg::KIND_KNOCK:
					warn = v >= t;
				gnp_pkg::KIND_BATTERY: warn = v <= t;
				gnp_pkg::KIND_FLAGS:   warn = v != 0;
				default:               warn = 1'b0;
			endcase
			if (!r.fresh) begin
				o.gauge_state = gnp_pkg::ST_STALE;
			end else if (warn) begin
				o.gauge_state = gnp_pkg::ST_WARNING;
			end else begin
				o.gauge_state = gnp_pkg::ST_NORMAL;
			end
		end
		o.position = p[gnp_pkg::POS_W-1:0];
		return o;
	endfunction

	function automatic gnp_pkg::in_t make_reading(input logic [2:0] kind,
			input logic [31:0] value, input logic [31:0] lo, input logic [31:0] hi,
			input logic valid, input logic fresh, input logic [31:0] now);
		gnp_pkg::in_t r;
		r.signal_kind = kind;
		r.value = value;
		r.range_min = lo;
		r.range_max = hi;
		r.valid_req = valid;
		r.fresh = fresh;
		r.now_ms = now;
		return r;
	endfunction

	// mostly well-formed readings with ranges and values around the thresholds
	function automatic gnp_pkg::in_t rand_reading();
		gnp_pkg::in_t r;
		int pick;
		longint c, lo, hi, v;
		r.signal_kind = 3'($urandom_range(gnp_pkg::KIND_NO_WARN));
		r.value = $urandom;
		r.range_min = $urandom;
		r.range_max = $urandom;
		r.valid_req = 1'b1;
		r.fresh = ($urandom_range(9) != 0);
		r.now_ms = $urandom;
		pick = $urandom_range(99);
		if (pick < 5) begin
			r.signal_kind = 3'($urandom_range(KIND_UNUSED, KIND_NO_ELEMENT));
			r.valid_req = 1'($urandom_range(1));
		end else if (pick < 15) begin
			r.valid_req = 1'b0;
		end else if (pick >= 25) begin
			c = (r.signal_kind == gnp_pkg::KIND_NO_WARN)
				? longint'($urandom_range(60000)) - 30000
				: warn_level(r.signal_kind);
			lo = c - longint'($urandom_range(20000, 1));
			hi = c + longint'($urandom_range(20000, 1));
			case ($urandom_range(9))
				0, 1, 2, 3: v = c + longint'($urandom_range(6)) - 3;
				4, 5, 6, 7: v = lo + longint'($urandom_range(int'(hi - lo) + 200)) - 100;
				8:          v = $urandom_range(1) ? lo : hi;
				default:    v = longint'($signed($urandom));
			endcase
			r.range_min = 32'(lo);
			r.range_max = 32'(hi);
			r.value = 32'(v);
		end
		return r;
	endfunction

	task automatic send_reading(input gnp_pkg::in_t r);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			reading_valid <= 1'b0;
			@(posedge clk);
		end
		reading_valid <= 1'b1;
		reading <= r;
		do @(posedge clk); while (!reading_ready);
		needle_q.push_back(predict_needle(r));
		sent_count++;
	endtask

	task automatic end_burst();
		reading_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_items(input int n);
		repeat (n) send_reading(rand_reading());
		end_burst();
	endtask

	task automatic wait_drained();
		while (needle_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [gnp_pkg::CFG_IW-1:0] idx,
			input logic [gnp_pkg::CFG_DW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gnp_pkg::REG_COOLANT:  thr.coolant_warn_level = data;
			gnp_pkg::REG_BATTERY:  thr.battery_low_level = data[11:0];
			gnp_pkg::REG_INJECTOR: thr.injector_duty_warn_level = data[13:0];
			gnp_pkg::REG_KNOCK:    thr.knock_warn_level = data[13:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input int cool, input int bat, input int inj, input int knock);
		write_threshold(gnp_pkg::REG_COOLANT, gnp_pkg::CFG_DW'(cool));
		write_threshold(gnp_pkg::REG_BATTERY, gnp_pkg::CFG_DW'(bat));
		write_threshold(gnp_pkg::REG_INJECTOR, gnp_pkg::CFG_DW'(inj));
		write_threshold(gnp_pkg::REG_KNOCK, gnp_pkg::CFG_DW'(knock));
		setting_count++;
	endtask

	task automatic test_directed();
		gnp_pkg::in_t items[$];
		items.push_back(make_reading(KIND_NO_ELEMENT, 32'd500, 32'd0, 32'd1000, 1'b1, 1'b1,
			$urandom));
		items.push_back(make_reading(KIND_UNUSED, 32'd5, 32'd0, 32'd10, 1'b1, 1'b0, $urandom));
		// sweep at start, rising, peak, end of period and wrap of the tick
		items.push_back(make_reading(gnp_pkg::KIND_COOLANT, 32'd0, 32'd0, 32'd1, 1'b0, 1'b1,
			32'd0));
		items.push_back(make_reading(gnp_pkg::KIND_BATTERY, 32'd0, 32'd0, 32'd1, 1'b0, 1'b1,
			32'd600));
		items.push_back(make_reading(gnp_pkg::KIND_KNOCK, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0,
			32'd1200));
		items.push_back(make_reading(gnp_pkg::KIND_FLAGS, 32'd0, 32'd0, 32'd1, 1'b0, 1'b1,
			32'd2399));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd0, 32'd0, 32'd1, 1'b0, 1'b1,
			32'hFFFF_FFFF));
		// empty ranges
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd7, 32'd7, 32'd7, 1'b1, 1'b1,
			32'd0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd7, 32'd9, 32'd3, 1'b1, 1'b1,
			32'd0));
		// range ends and beyond
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, -32'sd50, -32'sd50, 32'd50, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd50, -32'sd50, 32'd50, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, -32'sd51, -32'sd50, 32'd50, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd51, -32'sd50, 32'd50, 1'b1,
			1'b1, 0));
		// widest span, and the value extremes just outside near-widest spans
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'd0, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b1, 1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'h8000_0000, 32'h8000_0001,
			32'h7FFF_FFFF, 1'b1, 1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFE, 1'b1, 1'b1, 0));
		// stale wins over warning
		items.push_back(make_reading(gnp_pkg::KIND_COOLANT, 32'd12000, 32'd0, 32'd20000, 1'b1,
			1'b0, 0));
		// each kind on its threshold, and all but injector also just off it
		items.push_back(make_reading(gnp_pkg::KIND_COOLANT, 32'd10500, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_COOLANT, 32'd10499, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_BATTERY, 32'd1150, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_BATTERY, 32'd1151, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_INJECTOR, 32'd8500, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_KNOCK, 32'd299, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_KNOCK, 32'd300, 32'd0, 32'd20000, 1'b1,
			1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_FLAGS, 32'h8000_0000, 32'd0, 32'd20000,
			1'b1, 1'b1, 0));
		items.push_back(make_reading(gnp_pkg::KIND_FLAGS, 32'd0, 32'd0, 32'd20000, 1'b1, 1'b1,
			0));
		items.push_back(make_reading(gnp_pkg::KIND_NO_WARN, 32'h7FFF_FFFF, 32'd0, 32'd20000,
			1'b1, 1'b1, 0));
		foreach (items[i]) send_reading(items[i]);
		end_burst();
		wait_drained();
	endtask

	task automatic test_threshold_extremes();
		write_all(-4000, 0, 0, 0);
		run_items(80);
		wait_drained();
		write_all(25000, 3000, 10000, 10000);
		run_items(80);
		wait_drained();
		// full-width data, upper bits dropped by the narrow registers
		write_all($urandom, $urandom, $urandom, $urandom);
		// writes past the last register must leave the thresholds alone
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
			write_threshold(gnp_pkg::CFG_IW'(i), gnp_pkg::CFG_DW'($urandom));
		end
		run_items(80);
		wait_drained();
	endtask

	task automatic run_idle_phase(input int send_idle, input int recv_stall);
		write_all(int'($urandom_range(29000)) - 4000, $urandom_range(3000),
			$urandom_range(10000), $urandom_range(10000));
		idle_pct = send_idle;
		stall_pct = recv_stall;
		run_items(150);
		wait_drained();
	endtask

	task automatic test_idle_phases();
		run_idle_phase(0, 0);
		run_idle_phase(51, 0);
		run_idle_phase(0, 51);
		run_idle_phase(13, 13);
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_output_holdoff();
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		run_items(80);
		wait_drained();
	endtask

	// receiver: random stalls, plus a counted hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			needle_ready <= 1'b0;
			hold_left--;
		end else begin
			needle_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		gnp_pkg::out_t want;
		if (arst_n && needle_valid && needle_ready) begin
			if (needle_q.size() == 0) begin
				$error("needle word with no reading pending: position %0d off_scale %0d state %0d",
					needle.position, needle.off_scale, needle.gauge_state);
				mismatches++;
			end else begin
				want = needle_q.pop_front();
				checked_count++;
				if (needle.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, needle.position);
					mismatches++;
				end
				if (needle.off_scale !== want.off_scale) begin
					$error("off_scale: expected %0d, got %0d", want.off_scale, needle.off_scale);
					mismatches++;
				end
				if (needle.gauge_state !== want.gauge_state) begin
					$error("gauge_state: expected %0d, got %0d", want.gauge_state,
						needle.gauge_state);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles where neither side moves a word
	always @(posedge clk) begin
		if (!arst_n || (reading_valid && reading_ready) || (needle_valid && needle_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL gauge_needle_position_and_state_unit");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reading_valid = 1'b0;
		reading = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		sent_count = 0;
		checked_count = 0;
		setting_count = 1;
		mismatches = 0;
		stuck_cycles = 0;
		thr.coolant_warn_level = 16'sd10500;
		thr.battery_low_level = 12'd1150;
		thr.injector_duty_warn_level = 14'd8500;
		thr.knock_warn_level = 14'd300;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_extremes();
		test_idle_phases();
		test_output_holdoff();

		wait_drained();
		$display("covered %0d readings and %0d needle words over %0d threshold settings,",
			sent_count, checked_count, setting_count);
		$display("with sweep, empty and off-scale ranges, idle and stall mixes and a full backup");
		if (mismatches == 0) begin
			$display("PASS gauge_needle_position_and_state_unit");
		end else begin
			$display("FAIL gauge_needle_position_and_state_unit");
		end
		$finish;
	end

endmodule
